// File: src/bitg_pkg.sv
// Package for the binaural and isochronic tone generator.
// Holds the widths, command, mode and register codes, and the quarter-wave sine table.
// No dependencies.
`default_nettype none

package bitg_pkg;

    localparam int PHASE_W    = 32;
    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH);
    localparam int QTR        = SINE_DEPTH / 4;
    localparam int QA_W       = IDX_W - 1;
    localparam int SMP_W      = 16;
    localparam int AMP_W      = 15;

    // Commands carried by an input request.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_PAUSE  = 3'd3;
    localparam logic [2:0] CMD_RESUME = 3'd4;
    localparam logic [2:0] CMD_COH    = 3'd5;

    // Tone modes.
    localparam logic [1:0] MODE_BIN  = 2'd0;
    localparam logic [1:0] MODE_ISO  = 2'd1;
    localparam logic [1:0] MODE_COMB = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TONE_MODE    = 3'd0;
    localparam logic [2:0] REG_CARRIER_STEP = 3'd1;
    localparam logic [2:0] REG_BEAT_STEP    = 3'd2;
    localparam logic [2:0] REG_BREATH_STEP  = 3'd3;
    localparam logic [2:0] REG_BASE_AMP     = 3'd4;
    localparam logic [2:0] REG_ADAPTIVE     = 3'd5;
    localparam logic [2:0] REG_SESSION_LEN  = 3'd6;

    // Polynomial coefficients in Q2.30 for the sine table.
    localparam longint unsigned PC1 = 64'd1686629713;
    localparam longint unsigned PC3 = 64'd693598671;
    localparam longint unsigned PC5 = 64'd85569278;
    localparam longint unsigned PC7 = 64'd5026937;

    typedef logic [SMP_W-2:0] qtab_t [0:QTR];

    // Quarter-wave table in Q0.15, evaluated once at elaboration.
    function automatic qtab_t build_qtab();
        qtab_t           tab;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned p;
        longint unsigned s;
        longint unsigned v;
        longint unsigned cap;
        cap = (64'd1 << (SMP_W - 1)) - 64'd1;
        for (int r = 0; r <= QTR; r++) begin
            t  = (64'(r) << 30) / QTR;
            t2 = (t * t) >> 30;
            p  = PC5 - ((t2 * PC7) >> 30);
            p  = PC3 - ((t2 * p) >> 30);
            p  = PC1 - ((t2 * p) >> 30);
            s  = (t * p) >> 30;
            v  = (s + (64'd1 << (30 - SMP_W))) >> (31 - SMP_W);
            if (v > cap) begin
                v = cap;
            end
            tab[r] = v[SMP_W-2:0];
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

endpackage

`default_nettype wire

// File: src/bitg_sine_lut.sv
// Registered sine lookup from a phase word, using the quarter-wave table.
// Depends on bitg_pkg.
`default_nettype none

module bitg_sine_lut (
    input  wire logic                           aclk,
    input  wire logic [bitg_pkg::PHASE_W-1:0]   phase,
    output logic signed [bitg_pkg::SMP_W-1:0]   sine_q
);
    import bitg_pkg::*;

    logic [IDX_W-1:0]   idx;
    logic [1:0]         quad;
    logic [IDX_W-3:0]   frac_idx;
    logic [QA_W-1:0]    addr;
    logic [SMP_W-2:0]   mag;
    logic signed [SMP_W-1:0] sine_next;

    always_comb begin
        idx      = phase[PHASE_W-1 -: IDX_W];
        quad     = idx[IDX_W-1 -: 2];
        frac_idx = idx[IDX_W-3:0];
        // Odd quadrants mirror the table.
        if (quad[0]) begin
            addr = QA_W'(QTR) - {1'b0, frac_idx};
        end else begin
            addr = {1'b0, frac_idx};
        end
        mag = QTAB[addr];
        if (quad[1]) begin
            sine_next = -$signed({1'b0, mag});
        end else begin
            sine_next = $signed({1'b0, mag});
        end
    end

    always_ff @(posedge aclk) begin
        sine_q <= sine_next;
    end

endmodule

`default_nettype wire

// File: src/bitg_scale.sv
// Shared scaling multiplier: signed sample times unsigned gain, rounded half away from zero.
// The shift is 15 for amplitude gains and 16 for envelope gains. Depends on bitg_pkg.
`default_nettype none

module bitg_scale (
    input  wire logic                           aclk,
    input  wire logic signed [bitg_pkg::SMP_W-1:0] val,
    input  wire logic [bitg_pkg::SMP_W-1:0]     gain,
    input  wire logic                           shift16,
    output logic signed [bitg_pkg::SMP_W-1:0]   scale_q
);
    import bitg_pkg::*;

    logic                    neg;
    logic [SMP_W:0]          mag;
    logic [2*SMP_W:0]        prod;
    logic [2*SMP_W:0]        rnd;
    logic [SMP_W:0]          res;
    logic [SMP_W:0]          signed_res;

    always_comb begin
        neg  = val[SMP_W-1];
        if (neg) begin
            mag = (SMP_W+1)'(0) - {val[SMP_W-1], val};
        end else begin
            mag = {1'b0, val};
        end
        prod = mag * gain;
        if (shift16) begin
            rnd = prod + ((2*SMP_W+1)'(1) << 15);
            res = rnd[SMP_W+16:16];
        end else begin
            rnd = prod + ((2*SMP_W+1)'(1) << 14);
            res = rnd[SMP_W+15:15];
        end
        if (neg) begin
            signed_res = (SMP_W+1)'(0) - res;
        end else begin
            signed_res = res;
        end
    end

    always_ff @(posedge aclk) begin
        scale_q <= $signed(signed_res[SMP_W-1:0]);
    end

endmodule

`default_nettype wire

// File: src/binaural_isochronic_tone_gen.sv
// Stereo tone generator for binaural beats and isochronic tones, one sample per tick request.
// A non-tick command gives no result. A tick while idle or paused gives a silent sample
// through the output step; an active tick walks the lookup, multiply and mixing steps, plus
// the breathing envelope steps when the breathing step is nonzero. A new request is taken
// only after the sample has been handed to the output register, since every step shares the
// single sine table port and the single scaling multiplier. Reset (aresetn, low, synchronous)
// clears the session, the phases and the count and restores register defaults.
`default_nettype none

module binaural_isochronic_tone_gen (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // Configuration write port.
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata,

    // Input requests.
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic [15:0]        s_coherence,

    // Result requests.
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_left_sample,
    output logic signed [15:0]      m_right_sample,
    output logic                    m_session_running,
    output logic                    m_session_ended
);
    import bitg_pkg::*;

    // Sequencer states. Each active tick walks the lookup and multiply steps in order;
    // the sine table and multiplier outputs are each registered.
    localparam logic [3:0] ST_IDLE = 4'd0;  // waiting for a request
    localparam logic [3:0] ST_LC   = 4'd1;  // look up the carrier sine
    localparam logic [3:0] ST_LR   = 4'd2;  // look up the right sine, scale the carrier
    localparam logic [3:0] ST_ML   = 4'd3;  // scale the right sine, capture left
    localparam logic [3:0] ST_MR   = 4'd4;  // capture right, look up the envelope sine
    localparam logic [3:0] ST_MIX  = 4'd5;  // mode mixing, envelope, phase and count update
    localparam logic [3:0] ST_BL   = 4'd6;  // envelope on left
    localparam logic [3:0] ST_BR   = 4'd7;  // envelope on right, capture left
    localparam logic [3:0] ST_BW   = 4'd8;  // capture right
    localparam logic [3:0] ST_OUT  = 4'd9;  // hand the sample to the output register

    // Reciprocal of ten for the coherence mapping: floor(x * RECIP10 / 2^22) equals
    // floor(x / 10) for every numerator that can occur here.
    localparam logic [18:0] RECIP10 = 19'd419431;

    // Configuration registers.
    logic [1:0]         tone_mode_reg;
    logic [31:0]        carrier_step_reg;
    logic [31:0]        beat_step_reg;
    logic [31:0]        breath_step_reg;
    logic [AMP_W-1:0]   base_amp_reg;
    logic               adaptive_reg;
    logic [31:0]        session_len_reg;

    // Session state.
    logic [3:0]         state_reg, state_next;
    logic [PHASE_W-1:0] carrier_ph_reg, carrier_ph_next;
    logic [PHASE_W-1:0] right_ph_reg, right_ph_next;
    logic [PHASE_W-1:0] gate_ph_reg, gate_ph_next;
    logic [PHASE_W-1:0] breath_ph_reg, breath_ph_next;
    logic [31:0]        elapsed_reg, elapsed_next;
    logic               active_reg, active_next;
    logic               paused_reg, paused_next;
    logic [AMP_W-1:0]   work_amp_reg, work_amp_next;

    // Working sample registers.
    logic signed [SMP_W-1:0] left_reg, left_next;
    logic signed [SMP_W-1:0] right_reg, right_next;
    logic [SMP_W-1:0]        env_reg, env_next;
    logic                    ended_reg, ended_next;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic signed [SMP_W-1:0] out_left_reg, out_left_next;
    logic signed [SMP_W-1:0] out_right_reg, out_right_next;
    logic                    out_run_reg, out_run_next;
    logic                    out_end_reg, out_end_next;

    // Shared units.
    logic [PHASE_W-1:0]      lut_phase;
    logic signed [SMP_W-1:0] sine_q;
    logic signed [SMP_W-1:0] mul_val;
    logic [SMP_W-1:0]        mul_gain;
    logic                    mul_shift16;
    logic signed [SMP_W-1:0] scale_q;

    // Helpers.
    logic                    accept;
    logic [17:0]             coh_num;
    logic [36:0]             coh_prod;
    logic                    gate_open;
    logic signed [SMP_W-1:0] iso;
    logic signed [SMP_W:0]   iso_half;
    logic [31:0]             elapsed_inc;

    bitg_sine_lut u_sine (
        .aclk   (aclk),
        .phase  (lut_phase),
        .sine_q (sine_q)
    );

    bitg_scale u_scale (
        .aclk    (aclk),
        .val     (mul_val),
        .gain    (mul_gain),
        .shift16 (mul_shift16),
        .scale_q (scale_q)
    );

    // Clamp a widened sum back into the signed sample range.
    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [SMP_W:0] v);
        logic signed [SMP_W:0] hi;
        logic signed [SMP_W:0] lo;
        hi = (SMP_W+1)'((1 << (SMP_W - 1)) - 1);
        lo = -(SMP_W+1)'(1 << (SMP_W - 1));
        if (v > hi) begin
            return hi[SMP_W-1:0];
        end else if (v < lo) begin
            return lo[SMP_W-1:0];
        end
        return v[SMP_W-1:0];
    endfunction

    assign s_ready           = (state_reg == ST_IDLE);
    assign accept            = s_valid && s_ready;
    assign m_valid           = m_valid_reg;
    assign m_left_sample     = out_left_reg;
    assign m_right_sample    = out_right_reg;
    assign m_session_running = out_run_reg;
    assign m_session_ended   = out_end_reg;

    // The sine table is pointed at whichever phase the current step needs.
    always_comb begin
        case (state_reg)
            ST_LR:   lut_phase = right_ph_reg;
            ST_MR:   lut_phase = breath_ph_reg;
            default: lut_phase = carrier_ph_reg;
        endcase
    end

    // The multiplier takes the amplitude gain for the two tone steps and the
    // envelope gain for the two breathing steps.
    always_comb begin
        mul_val     = sine_q;
        mul_gain    = {1'b0, work_amp_reg};
        mul_shift16 = 1'b0;
        case (state_reg)
            ST_BL: begin
                mul_val     = left_reg;
                mul_gain    = env_reg;
                mul_shift16 = 1'b1;
            end
            ST_BR: begin
                mul_val     = right_reg;
                mul_gain    = env_reg;
                mul_shift16 = 1'b1;
            end
            default: begin
                mul_val     = sine_q;
                mul_gain    = {1'b0, work_amp_reg};
                mul_shift16 = 1'b0;
            end
        endcase
    end

    always_comb begin
        coh_num     = 18'd65541 + 18'(s_coherence);
        coh_prod    = coh_num * RECIP10;
        // The gate is open in the first half of the beat cycle, phase zero excluded.
        gate_open   = (gate_ph_reg != '0) && !gate_ph_reg[PHASE_W-1];
        iso         = gate_open ? left_reg : '0;
        // Half of the isochronic sample, truncated toward zero.
        iso_half    = $signed({iso[SMP_W-1], iso} + (SMP_W+1)'(iso[SMP_W-1])) >>> 1;
        elapsed_inc = (elapsed_reg == 32'hFFFF_FFFF) ? elapsed_reg : elapsed_reg + 32'd1;
    end

    // Sequencer and session state.
    always_comb begin
        state_next      = state_reg;
        carrier_ph_next = carrier_ph_reg;
        right_ph_next   = right_ph_reg;
        gate_ph_next    = gate_ph_reg;
        breath_ph_next  = breath_ph_reg;
        elapsed_next    = elapsed_reg;
        active_next     = active_reg;
        paused_next     = paused_reg;
        work_amp_next   = work_amp_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        env_next        = env_reg;
        ended_next      = ended_reg;
        m_valid_next    = m_valid_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_run_next    = out_run_reg;
        out_end_next    = out_end_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        CMD_TICK: begin
                            if (active_reg && !paused_reg) begin
                                state_next = ST_LC;
                            end else begin
                                // Silent sample; nothing advances.
                                left_next  = '0;
                                right_next = '0;
                                ended_next = 1'b0;
                                state_next = ST_OUT;
                            end
                        end
                        CMD_START: begin
                            active_next   = 1'b1;
                            paused_next   = 1'b0;
                            elapsed_next  = '0;
                            work_amp_next = base_amp_reg;
                        end
                        CMD_STOP: begin
                            active_next = 1'b0;
                            paused_next = 1'b0;
                        end
                        CMD_PAUSE: begin
                            paused_next = 1'b1;
                        end
                        CMD_RESUME: begin
                            paused_next = 1'b0;
                        end
                        CMD_COH: begin
                            // Amplitude follows 0.2 + 0.2 * coherence.
                            if (adaptive_reg && active_reg) begin
                                work_amp_next = coh_prod[AMP_W+21:22];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LC: begin
                state_next = ST_LR;
            end
            ST_LR: begin
                state_next = ST_ML;
            end
            ST_ML: begin
                left_next  = scale_q;
                state_next = ST_MR;
            end
            ST_MR: begin
                right_next = scale_q;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                if (tone_mode_reg == MODE_ISO) begin
                    left_next  = iso;
                    right_next = iso;
                end else if (tone_mode_reg == MODE_COMB) begin
                    left_next  = sat_smp({left_reg[SMP_W-1], left_reg} + iso_half);
                    right_next = sat_smp({right_reg[SMP_W-1], right_reg} + iso_half);
                end
                // Envelope 0.5 + 0.5 * sin as Q0.16: offset by half scale.
                env_next        = SMP_W'(sine_q) + (SMP_W'(1) << (SMP_W - 1));
                carrier_ph_next = carrier_ph_reg + carrier_step_reg;
                right_ph_next   = right_ph_reg + carrier_step_reg + beat_step_reg;
                if (tone_mode_reg inside {MODE_ISO, MODE_COMB}) begin
                    gate_ph_next = gate_ph_reg + beat_step_reg;
                end
                if (breath_step_reg != '0) begin
                    breath_ph_next = breath_ph_reg + breath_step_reg;
                    state_next     = ST_BL;
                end else begin
                    state_next = ST_OUT;
                end
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= session_len_reg) begin
                    active_next = 1'b0;
                    paused_next = 1'b0;
                    ended_next  = 1'b1;
                end else begin
                    ended_next = 1'b0;
                end
            end
            ST_BL: begin
                state_next = ST_BR;
            end
            ST_BR: begin
                left_next  = scale_q;
                state_next = ST_BW;
            end
            ST_BW: begin
                right_next = scale_q;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Wait for the output register to free up.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_left_next  = left_reg;
                    out_right_next = right_reg;
                    out_run_next   = active_reg;
                    out_end_next   = ended_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            carrier_ph_reg   <= '0;
            right_ph_reg     <= '0;
            gate_ph_reg      <= '0;
            breath_ph_reg    <= '0;
            elapsed_reg      <= '0;
            active_reg       <= 1'b0;
            paused_reg       <= 1'b0;
            work_amp_reg     <= AMP_W'(9830);
            m_valid_reg      <= 1'b0;
            tone_mode_reg    <= MODE_BIN;
            carrier_step_reg <= 32'd17895697;
            beat_step_reg    <= 32'd894785;
            breath_step_reg  <= 32'd17895;
            base_amp_reg     <= AMP_W'(9830);
            adaptive_reg     <= 1'b0;
            session_len_reg  <= 32'd28800000;
        end else begin
            state_reg      <= state_next;
            carrier_ph_reg <= carrier_ph_next;
            right_ph_reg   <= right_ph_next;
            gate_ph_reg    <= gate_ph_next;
            breath_ph_reg  <= breath_ph_next;
            elapsed_reg    <= elapsed_next;
            active_reg     <= active_next;
            paused_reg     <= paused_next;
            work_amp_reg   <= work_amp_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TONE_MODE:    tone_mode_reg    <= cfg_wdata[1:0];
                    REG_CARRIER_STEP: carrier_step_reg <= cfg_wdata;
                    REG_BEAT_STEP:    beat_step_reg    <= cfg_wdata;
                    REG_BREATH_STEP:  breath_step_reg  <= cfg_wdata;
                    REG_BASE_AMP:     base_amp_reg     <= cfg_wdata[AMP_W-1:0];
                    REG_ADAPTIVE:     adaptive_reg     <= cfg_wdata[0];
                    REG_SESSION_LEN:  session_len_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        left_reg      <= left_next;
        right_reg     <= right_next;
        env_reg       <= env_next;
        ended_reg     <= ended_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_run_reg   <= out_run_next;
        out_end_reg   <= out_end_next;
    end

endmodule

`default_nettype wire
